// ----- design/ogg_page_packet_deframer_assert.svh -----
`ifndef OGG_PAGE_PACKET_DEFRAMER_ASSERT_SVH
`define OGG_PAGE_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define OPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/opd_pkg.sv -----
package opd_pkg;

  localparam int unsigned MaxSegmentsDefault = 255;
  localparam int unsigned HeaderLast         = 26;
  localparam int unsigned MinIdBytes         = 19;
  localparam int unsigned MinTagsBytes       = 12;

  localparam logic [31:0] PageMagic     = 32'h4F67_6753;
  localparam logic [63:0] OpusHeadMagic = 64'h4F70_7573_4865_6164;
  localparam logic [63:0] OpusTagsMagic = 64'h4F70_7573_5461_6773;

  typedef enum logic [3:0] {
    ST_DATA       = 4'd0,
    ST_ID_OK      = 4'd1,
    ST_TAGS_OK    = 4'd2,
    ST_PAGE_MAGIC = 4'd3,
    ST_NO_SEGS    = 4'd4,
    ST_ID_MAGIC   = 4'd5,
    ST_TAGS_MAGIC = 4'd6,
    ST_TOO_SHORT  = 4'd7,
    ST_TRUNCATED  = 4'd8
  } status_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    status_e    status;
    logic       packet_end;
  } out_t;

  // One nonzero lace of the table, with a mark that a zero lace came just before it.
  typedef struct packed {
    logic       zero_before;
    logic [7:0] lace;
  } seg_t;

  function automatic logic [7:0] opus_magic(logic tags, logic [2:0] idx);
    logic [63:0] m;
    m = tags ? OpusTagsMagic : OpusHeadMagic;
    return m[63 - 8 * idx -: 8];
  endfunction

endpackage

// ----- design/opd_seg_ram.sv -----
module opd_seg_ram import opd_pkg::*; #(
  parameter int unsigned Depth = MaxSegmentsDefault,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  seg_t             wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output seg_t             rdata_o
);

  seg_t mem_q [Depth];
  seg_t rdata_q;

  // A write to the entry being read in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && waddr_i == raddr_i) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ogg_page_packet_deframer.sv -----
// A result appears on the output register in the cycle after its byte is transferred.
// Throughput: one byte per cycle in every phase unless the output stalls; the next entry
// is prefetched from the single-port-read segment table RAM, whose read data is registered.
// Reset: asynchronous, active low; the parser returns to the page header and
// expect_q reads 1. The segment table RAM is not cleared.
module ogg_page_packet_deframer import opd_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_data_i
);

  localparam int unsigned AddrW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_SEGMENTS + 1);

  localparam logic [2:0] PhHeader   = 3'd0;
  localparam logic [2:0] PhTable    = 3'd1;
  localparam logic [2:0] PhData     = 3'd2;
  localparam logic [2:0] PhHeadPage = 3'd3;
  localparam logic [2:0] PhSkip     = 3'd4;

  logic [2:0]      phase_q, phase_d;
  logic [4:0]      hcnt_q, hcnt_d;
  logic [23:0]     sig_q, sig_d;
  logic            sig_ok_q, sig_ok_d;
  logic [CntW-1:0] seg_cnt_q, seg_cnt_d;
  logic [CntW-1:0] tidx_q, tidx_d;
  logic [CntW-1:0] wptr_q, wptr_d;
  logic            prev_zero_q, prev_zero_d;
  logic [7:0]      first_lace_q, first_lace_d;
  logic [15:0]     pl_sum_q, pl_sum_d;
  logic [1:0]      ord_q, ord_d;
  logic [7:0]      cur_rem_q, cur_rem_d;
  logic            cur_lt255_q, cur_lt255_d;
  logic [CntW-1:0] nxt_idx_q, nxt_idx_d;
  logic [CntW-1:0] n_ent_q, n_ent_d;
  logic            tail_zero_q, tail_zero_d;
  logic [15:0]     pl_left_q, pl_left_d;
  logic [3:0]      mpos_q, mpos_d;
  logic            hmatch_q, hmatch_d;
  logic            expect_q;
  logic            out_valid_q;
  out_t            out_q;

  logic            accept;
  logic            res_valid;
  out_t            res;
  logic            we;
  seg_t            wdata;
  seg_t            rd_data;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  opd_seg_ram #(
    .Depth (MAX_SEGMENTS),
    .AddrW (AddrW)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wptr_q[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (nxt_idx_d[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    logic [7:0]      b;
    logic [15:0]     sum;
    logic [15:0]     need;
    logic [CntW-1:0] tidx_inc;
    logic [7:0]      first;
    logic            has_nxt;
    logic            match_now;

    b         = in_data_i.byte_in;
    sum       = pl_sum_q + 16'(b);
    need      = (ord_q == 2'd0) ? 16'(MinIdBytes) : 16'(MinTagsBytes);
    tidx_inc  = tidx_q + CntW'(1);
    first     = (wptr_q == '0) ? b : first_lace_q;
    has_nxt   = nxt_idx_q < n_ent_q;
    match_now = hmatch_q &&
                !(mpos_q < 4'd8 && b != opus_magic(ord_q[0], mpos_q[2:0]));

    phase_d      = phase_q;
    hcnt_d       = hcnt_q;
    sig_d        = sig_q;
    sig_ok_d     = sig_ok_q;
    seg_cnt_d    = seg_cnt_q;
    tidx_d       = tidx_q;
    wptr_d       = wptr_q;
    prev_zero_d  = prev_zero_q;
    first_lace_d = first_lace_q;
    pl_sum_d     = pl_sum_q;
    ord_d        = ord_q;
    cur_rem_d    = cur_rem_q;
    cur_lt255_d  = cur_lt255_q;
    nxt_idx_d    = nxt_idx_q;
    n_ent_d      = n_ent_q;
    tail_zero_d  = tail_zero_q;
    pl_left_d    = pl_left_q;
    mpos_d       = mpos_q;
    hmatch_d     = hmatch_q;

    res_valid      = 1'b0;
    res.byte_out   = 8'd0;
    res.status     = ST_DATA;
    res.packet_end = 1'b0;
    we             = 1'b0;
    wdata.zero_before = prev_zero_q;
    wdata.lace        = b;

    if (accept) begin
      case (phase_q)
        PhHeader: begin
          sig_d = {sig_q[15:0], b};
          if (hcnt_q == 5'd3) begin
            sig_ok_d = ({sig_q, b} == PageMagic);
          end
          if (hcnt_q != 5'(HeaderLast)) begin
            hcnt_d = hcnt_q + 5'd1;
          end else begin
            hcnt_d = 5'd0;
            if (!sig_ok_q) begin
              res_valid  = 1'b1;
              res.status = ST_PAGE_MAGIC;
              phase_d    = PhSkip;
            end else if (b == 8'd0 || b > 8'(MAX_SEGMENTS)) begin
              res_valid  = 1'b1;
              res.status = ST_NO_SEGS;
              phase_d    = PhSkip;
            end else begin
              seg_cnt_d   = CntW'(b);
              tidx_d      = '0;
              wptr_d      = '0;
              pl_sum_d    = 16'd0;
              prev_zero_d = 1'b0;
              phase_d     = PhTable;
            end
          end
        end
        PhTable: begin
          pl_sum_d    = sum;
          tidx_d      = tidx_inc;
          prev_zero_d = (b == 8'd0);
          if (b != 8'd0) begin
            we     = 1'b1;
            wptr_d = wptr_q + CntW'(1);
            if (wptr_q == '0) begin
              first_lace_d = b;
            end
          end
          if (tidx_inc >= seg_cnt_q) begin
            pl_left_d = sum;
            mpos_d    = 4'd0;
            hmatch_d  = 1'b1;
            if (expect_q && ord_q < 2'd2) begin
              if (sum < need) begin
                res_valid  = 1'b1;
                res.status = ST_TOO_SHORT;
                phase_d    = PhSkip;
              end else begin
                phase_d = PhHeadPage;
              end
            end else if (sum == 16'd0) begin
              phase_d = PhHeader;
            end else begin
              phase_d     = PhData;
              cur_rem_d   = first;
              cur_lt255_d = (first != 8'hFF);
              nxt_idx_d   = CntW'(1);
              n_ent_d     = wptr_d;
              tail_zero_d = (b == 8'd0);
            end
          end
        end
        PhData: begin
          res_valid    = 1'b1;
          res.byte_out = b;
          if (cur_rem_q == 8'd1) begin
            res.packet_end = cur_lt255_q || (has_nxt ? rd_data.zero_before : tail_zero_q);
            if (!has_nxt) begin
              phase_d = PhHeader;
            end else begin
              cur_rem_d   = rd_data.lace;
              cur_lt255_d = (rd_data.lace != 8'hFF);
              nxt_idx_d   = nxt_idx_q + CntW'(1);
            end
          end else begin
            cur_rem_d = cur_rem_q - 8'd1;
          end
        end
        PhHeadPage: begin
          hmatch_d  = match_now;
          pl_left_d = pl_left_q - 16'd1;
          if (mpos_q != 4'd8) begin
            mpos_d = mpos_q + 4'd1;
          end
          if (pl_left_q == 16'd1) begin
            res_valid = 1'b1;
            if (match_now) begin
              res.status = ord_q[0] ? ST_TAGS_OK : ST_ID_OK;
              ord_d      = ord_q + 2'd1;
              phase_d    = PhHeader;
            end else begin
              res.status = ord_q[0] ? ST_TAGS_MAGIC : ST_ID_MAGIC;
              phase_d    = PhSkip;
            end
          end
        end
        default: begin
        end
      endcase

      if (in_data_i.stream_end) begin
        if (phase_d != PhSkip && !(phase_d == PhHeader && hcnt_d == 5'd0)) begin
          res_valid      = 1'b1;
          res.byte_out   = 8'd0;
          res.status     = ST_TRUNCATED;
          res.packet_end = 1'b0;
        end
        phase_d = PhHeader;
        hcnt_d  = 5'd0;
        ord_d   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      hcnt_q      <= 5'd0;
      ord_q       <= 2'd0;
      expect_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      ord_q   <= ord_d;
      if (cfg_valid_i) begin
        expect_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        out_valid_q <= accept && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sig_q        <= sig_d;
    sig_ok_q     <= sig_ok_d;
    seg_cnt_q    <= seg_cnt_d;
    tidx_q       <= tidx_d;
    wptr_q       <= wptr_d;
    prev_zero_q  <= prev_zero_d;
    first_lace_q <= first_lace_d;
    pl_sum_q     <= pl_sum_d;
    cur_rem_q    <= cur_rem_d;
    cur_lt255_q  <= cur_lt255_d;
    nxt_idx_q    <= nxt_idx_d;
    n_ent_q      <= n_ent_d;
    tail_zero_q  <= tail_zero_d;
    pl_left_q    <= pl_left_d;
    mpos_q       <= mpos_d;
    hmatch_q     <= hmatch_d;
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

endmodule

// ----- design/opd_checker.sv -----
`include "ogg_page_packet_deframer_assert.svh"

module opd_checker import opd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o,
  input logic cfg_data_i
);

  `OPD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "Stalled result changed.")
  `OPD_ASSERT_IMP(a_status_clean, clk_i, rst_ni, out_valid_o && out_data_o.status != ST_DATA, out_data_o.byte_out == 8'd0 && !out_data_o.packet_end, "Status result carries data.")
  `OPD_ASSERT_IMP(a_stall_blocks_input, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o, "Input taken while result stalled.")
  `OPD_ASSERT_IMP(a_result_has_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && in_ready_o), "Result without an input transfer.")

endmodule

bind ogg_page_packet_deframer opd_checker u_opd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i)
);
